@@ src/cobsenc_pkg.sv @@
// Shared constants and types of the COBS frame encoder.
package cobsenc_pkg;

   localparam int MAX_RUN    = 254;
   localparam int BEAT_BYTES = 8;

   localparam int BYTE_W  = 8;
   localparam int RUN_AW  = 8;
   localparam int LEN_W   = 9;
   localparam int LANE_W  = 3;
   localparam int CNT_W   = 4;
   localparam int BEAT_W  = BEAT_BYTES * BYTE_W;

   localparam logic [BYTE_W-1:0] FULL_CODE  = 8'hFF;
   localparam logic [BYTE_W-1:0] CODE_ONE   = 8'h01;
   localparam logic [BYTE_W-1:0] DELIM_BYTE = 8'h00;
   localparam logic [RUN_AW-1:0] LAST_SLOT  = RUN_AW'(MAX_RUN - 1);

   typedef struct packed {
      logic              vld;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              delim;
   } byte_xfer_type;

   typedef struct packed {
      logic              vld;
      logic              from_store;
      logic [BYTE_W-1:0] fixed_byte;
      logic              last;
      logic              delim;
   } read_slot_type;

endpackage

@@ src/cobsenc_packer.sv @@
// Beat packer: collects encoded bytes into beats and holds the output register.
module cobsenc_packer (
   input  logic                                        clock,
   input  logic                                        reset,
   input  cobsenc_pkg::byte_xfer_type                  byte_in,
   output logic                                        byte_take,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [cobsenc_pkg::BEAT_W-1:0]              rsp_beat_bytes,
   output logic [cobsenc_pkg::CNT_W-1:0]               rsp_byte_count,
   output logic                                        rsp_frame_end,
   output logic                                        rsp_last_of_run
);
   import cobsenc_pkg::*;

   logic [BEAT_W-1:0] asm_bytes_ff, asm_bytes_in;
   logic [LANE_W-1:0] asm_cnt_ff, asm_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BEAT_W-1:0] rsp_bytes_ff, rsp_bytes_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_frame_ff, rsp_frame_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              beat_done;
   logic [BEAT_W-1:0] merged;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign beat_done = byte_in.last || (asm_cnt_ff == LANE_W'(BEAT_BYTES - 1));
   assign byte_take = byte_in.vld && (!beat_done || out_free);
   assign merged    = asm_bytes_ff |
                      ({{(BEAT_W-BYTE_W){1'b0}}, byte_in.data} << {asm_cnt_ff, 3'b000});

   always_comb begin
      asm_bytes_in = asm_bytes_ff;
      asm_cnt_in   = asm_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_count_in = rsp_count_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_last_in  = rsp_last_ff;
      if (byte_take && beat_done) begin
         rsp_valid_in = 1'b1;
         rsp_bytes_in = merged;
         rsp_count_in = {1'b0, asm_cnt_ff} + CNT_W'(1);
         rsp_frame_in = byte_in.last && byte_in.delim;
         rsp_last_in  = byte_in.last;
         asm_bytes_in = '0;
         asm_cnt_in   = '0;
      end else begin
         if (byte_take) begin
            asm_bytes_in = merged;
            asm_cnt_in   = asm_cnt_ff + LANE_W'(1);
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_bytes_ff <= '0;
         asm_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         asm_bytes_ff <= asm_bytes_in;
         asm_cnt_ff   <= asm_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_count_ff <= rsp_count_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_beat_bytes  = rsp_bytes_ff;
   assign rsp_byte_count  = rsp_count_ff;
   assign rsp_frame_end   = rsp_frame_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

@@ src/cobs_frame_encoder_unit.sv @@
// Top level of the COBS frame encoder: run store, block sequencer and beat output.
//
// Input channel (req_): one raw payload byte per transaction, with
// req_end_of_packet on the final byte. Result channel (rsp_): beats of up to
// eight encoded bytes, first byte in lane 0, unused lanes zero; rsp_frame_end
// marks the beat ending in the 0x00 delimiter, rsp_last_of_run the last beat
// caused by one input byte.
// Nonzero bytes that neither fill a run nor end the packet are written to the
// run store with no result.
// A byte that ends a block emits L = code + run bytes, plus at packet end a
// 0x01 code (after a zero) and the 0x00 delimiter, up to 256 in all. The
// sequencer reads the run store one byte per cycle while the packer takes its
// bytes; each waits in the read slot (store bytes in a registered read) until
// taken, and the packer gathers up to eight into a beat for the output register.
// New input is taken as soon as the last byte has entered the beat packer,
// even while the final beat still waits in the output register.
// Reset empties the run and the output register; the run store itself keeps
// its contents and needs no clearing. A stalled receiver holds the output
// register, and the sequencer waits until the beat in progress can move out.
module cobs_frame_encoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_end_of_packet,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cobsenc_pkg::BEAT_W-1:0]      rsp_beat_bytes,
   output logic [cobsenc_pkg::CNT_W-1:0]       rsp_byte_count,
   output logic                                rsp_frame_end,
   output logic                                rsp_last_of_run
);
   import cobsenc_pkg::*;

   logic [BYTE_W-1:0] run_store [0:MAX_RUN-1];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [RUN_AW-1:0] rl_ff, rl_in;
   logic [BYTE_W-1:0] code_ff, code_in;
   logic [RUN_AW-1:0] n_ff, n_in;
   logic              tail_two_ff, tail_two_in;
   logic              delim_ff, delim_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   read_slot_type     slot_ff, slot_in;

   logic              req_take;
   logic              is_zero;
   logic              run_full;
   logic              draining;
   logic              slot_free;
   logic              issue;
   logic              wr_en;
   logic              rd_en;
   logic [RUN_AW-1:0] rd_addr;
   logic [LEN_W-1:0]  n_ext;
   logic              byte_take;
   byte_xfer_type     byte_xfer;

   assign draining  = pos_ff != len_ff;
   assign req_stall = draining || slot_ff.vld;
   assign req_take  = req_valid && !req_stall;
   assign is_zero   = req_data_byte == DELIM_BYTE;
   assign run_full  = rl_ff == LAST_SLOT;
   assign wr_en     = req_take && !is_zero;
   assign slot_free = !slot_ff.vld || byte_take;
   assign issue     = draining && slot_free;
   assign n_ext     = {1'b0, n_ff};
   assign rd_addr   = RUN_AW'(pos_ff - LEN_W'(1));

   always_comb begin
      rl_in       = rl_ff;
      code_in     = code_ff;
      n_in        = n_ff;
      tail_two_in = tail_two_ff;
      delim_in    = delim_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      if (req_take) begin
         delim_in    = req_end_of_packet;
         tail_two_in = 1'b0;
         pos_in      = '0;
         len_in      = '0;
         rl_in       = '0;
         priority if (is_zero) begin
            code_in     = rl_ff + RUN_AW'(1);
            n_in        = rl_ff;
            tail_two_in = req_end_of_packet;
            len_in      = {1'b0, rl_ff} + LEN_W'(1)
                          + (req_end_of_packet ? LEN_W'(2) : LEN_W'(0));
         end else if (run_full) begin
            code_in = FULL_CODE;
            n_in    = RUN_AW'(MAX_RUN);
            len_in  = LEN_W'(MAX_RUN + 1) + {{(LEN_W-1){1'b0}}, req_end_of_packet};
         end else if (req_end_of_packet) begin
            code_in = rl_ff + RUN_AW'(2);
            n_in    = rl_ff + RUN_AW'(1);
            len_in  = {1'b0, rl_ff} + LEN_W'(3);
         end else begin
            rl_in = rl_ff + RUN_AW'(1);
         end
      end else if (issue) begin
         pos_in = pos_ff + LEN_W'(1);
      end
   end

   always_comb begin
      slot_in = slot_ff;
      rd_en   = 1'b0;
      if (issue) begin
         slot_in.vld        = 1'b1;
         slot_in.from_store = (pos_ff != '0) && (pos_ff <= n_ext);
         slot_in.last       = pos_ff == (len_ff - LEN_W'(1));
         slot_in.delim      = delim_ff;
         priority if (pos_ff == '0) begin
            slot_in.fixed_byte = code_ff;
         end else if (tail_two_ff && (pos_ff == (n_ext + LEN_W'(1)))) begin
            slot_in.fixed_byte = CODE_ONE;
         end else begin
            slot_in.fixed_byte = DELIM_BYTE;
         end
         rd_en = slot_in.from_store;
      end else if (byte_take) begin
         slot_in.vld = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         run_store[rl_ff] <= req_data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= run_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rl_ff     <= '0;
         len_ff    <= '0;
         pos_ff    <= '0;
         slot_ff   <= '0;
      end else begin
         rl_ff     <= rl_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
         slot_ff   <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      n_ff        <= n_in;
      tail_two_ff <= tail_two_in;
      delim_ff    <= delim_in;
   end

   always_comb begin
      byte_xfer.vld   = slot_ff.vld;
      byte_xfer.data  = slot_ff.from_store ? rd_data_ff : slot_ff.fixed_byte;
      byte_xfer.last  = slot_ff.last;
      byte_xfer.delim = slot_ff.delim;
   end

   cobsenc_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .byte_in         (byte_xfer),
      .byte_take       (byte_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_beat_bytes  (rsp_beat_bytes),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && (rd_en || slot_ff.vld || draining)))
      else $error("run store written while a block is still being read");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      rl_ff <= LAST_SLOT)
      else $error("run length beyond store depth");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= len_ff)
      else $error("sequencer position past block length");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count != '0) && (rsp_byte_count <= CNT_W'(BEAT_BYTES)))
      else $error("beat byte count out of range");

   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_last_of_run)
      else $error("delimiter beat not marked as final beat");

endmodule

@@ tb/tb_cobs_frame_encoder_unit.sv @@
// Self-checking testbench for the COBS frame encoder unit.
`timescale 1ns / 100ps

module tb_cobs_frame_encoder_unit;
   import cobsenc_pkg::*;

   localparam int CYCLE_LIMIT  = 3000000;
   localparam int SETTLE_TICKS = 300;

   typedef struct {
      logic [BEAT_W-1:0] lanes;
      logic [CNT_W-1:0]  count;
      logic              frame_end;
      logic              last_beat;
   } encoded_beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = 8'h00;
   logic                req_end_of_packet = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BEAT_W-1:0]   rsp_beat_bytes;
   logic [CNT_W-1:0]    rsp_byte_count;
   logic                rsp_frame_end;
   logic                rsp_last_of_run;

   logic [BYTE_W-1:0]   run_bytes [MAX_RUN];
   int unsigned         run_fill = 0;
   bit                  after_full_block = 1'b0;
   logic [BYTE_W-1:0]   coded_bytes [$];
   encoded_beat_type    expected_beats [$];

   int unsigned         send_idle_pct = 0;
   int unsigned         recv_idle_pct = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count = 0;

   cobs_frame_encoder_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_packet (req_end_of_packet),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_beat_bytes    (rsp_beat_bytes),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic void flush_block(input logic [BYTE_W-1:0] code);
      coded_bytes.push_back(code);
      for (int i = 0; i < run_fill; i++)
         coded_bytes.push_back(run_bytes[i]);
      run_fill = 0;
   endfunction

   function automatic void predict_encoding(input logic [7:0] data, input logic eop);
      encoded_beat_type beat;
      int unsigned      take;
      coded_bytes.delete();
      if (data == 8'h00) begin
         flush_block(BYTE_W'(run_fill + 1));
         after_full_block = 1'b0;
      end else begin
         run_bytes[run_fill] = data;
         run_fill++;
         after_full_block = 1'b0;
         if (run_fill == MAX_RUN) begin
            flush_block(FULL_CODE);
            after_full_block = 1'b1;
         end
      end
      if (eop) begin
         if (!(after_full_block && run_fill == 0))
            flush_block(BYTE_W'(run_fill + 1));
         coded_bytes.push_back(DELIM_BYTE);
         run_fill = 0;
         after_full_block = 1'b0;
      end
      for (int pos = 0; pos < coded_bytes.size(); pos += BEAT_BYTES) begin
         take = coded_bytes.size() - pos;
         if (take > BEAT_BYTES)
            take = BEAT_BYTES;
         beat.lanes = '0;
         for (int k = 0; k < take; k++)
            beat.lanes[8*k +: 8] = coded_bytes[pos + k];
         beat.count     = CNT_W'(take);
         beat.last_beat = (pos + take) >= coded_bytes.size();
         beat.frame_end = beat.last_beat && eop;
         expected_beats.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      encoded_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: bytes %h count %0d", rsp_beat_bytes, rsp_byte_count);
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_beat_bytes !== want.lanes) begin
               $error("beat_bytes: expected %h, got %h", want.lanes, rsp_beat_bytes);
               mismatch_count++;
            end
            if (rsp_byte_count !== want.count) begin
               $error("byte_count: expected %0d, got %0d", want.count, rsp_byte_count);
               mismatch_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %b, got %b", want.frame_end, rsp_frame_end);
               mismatch_count++;
            end
            if (rsp_last_of_run !== want.last_beat) begin
               $error("last_of_run: expected %b, got %b", want.last_beat, rsp_last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   function automatic logic [7:0] pick_byte(input int unsigned zero_pct);
      if ($urandom_range(0, 99) < zero_pct)
         return 8'h00;
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic eop);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_end_of_packet <= eop;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_encoding(data, eop);
   endtask

   task automatic send_run(input int unsigned len, input bit close_packet);
      for (int i = 0; i < len; i++)
         send_byte(pick_byte(0), close_packet && (i == len - 1));
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic test_directed_bytes();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFE, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(8'h9A, 1'b0);
      send_byte(8'hBC, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_full_runs();
      // full run closing the packet: delimiter only after the 0xFF block
      send_run(MAX_RUN, 1'b1);
      // zero straight after a full block
      send_run(MAX_RUN, 1'b0);
      send_byte(8'h00, 1'b1);
      // run carrying on past a full block
      send_run(MAX_RUN + 3, 1'b1);
      // 253-byte run closed by a zero at packet end: 256 coded bytes, the most beats per transaction
      send_run(MAX_RUN - 1, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_random_packets(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned budget);
      int unsigned sent;
      int unsigned len;
      int unsigned zero_pct;
      sent          = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (sent < budget) begin
         if ($urandom_range(0, 15) == 0) begin
            len      = $urandom_range(MAX_RUN - 8, MAX_RUN + 10);
            zero_pct = $urandom_range(0, 1);
         end else begin
            len      = $urandom_range(1, 12);
            zero_pct = $urandom_range(10, 50);
         end
         for (int i = 0; i < len; i++)
            send_byte(pick_byte(zero_pct), i == len - 1);
         sent += len;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 34;
      recv_idle_pct = 56;
      test_directed_bytes();
      hold_until_drained();
      test_full_runs();
      hold_until_drained();
      test_random_packets(34, 56, 35);
      test_random_packets(56, 34, 35);
      test_random_packets(0, 0, 35);
      hold_until_drained();
      if (mismatch_count == 0 && expected_beats.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ cobs_frame_encoder_unit.f @@
src/cobsenc_pkg.sv
src/cobsenc_packer.sv
src/cobs_frame_encoder_unit.sv
tb/tb_cobs_frame_encoder_unit.sv
